[hw/rtl/spca_pkg.sv]
// Shared types, constants and helpers for the slotted page cell allocator.
`default_nettype none

package spca_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);
    localparam int IT_W       = ADDR_W + 1;
    localparam int ALU_W      = 18;

    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_DROP   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic        done;
        t_status     status;
        logic [11:0] data_offset;
        logic [10:0] cell_count;
    } t_seq_res;

    function automatic logic [ALU_W-1:0] x18(input logic [15:0] v);
        return {{(ALU_W-16){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/slotted_page_cell_allocator_unit.sv]
// Top level of the slotted page cell allocator.
`default_nettype none

// Slotted page cell allocator. A 4096-byte page holds a 12-byte header, a
// slot array of 16-bit cell offsets growing up from byte 12, and an
// address-ordered free list. Each input transaction carries one operation
// (format, allocate, drop, or a no-op) and produces exactly one result
// transaction with status, payload offset and cell count. One operation is
// in flight at a time: o_s_axis_tready is high only while the sequencer is idle.
// The pace is set by the single byte-wide page memory port. A 16-bit field
// read or write is issued by one step and takes two byte accesses (RD0/RD1
// or WR0/WR1); each byte moved is read, then written (CP0, CP1).
// Allocate walks the free list block by block and gives up early when the
// first free block is too small. Drop time depends on merges, on the bytes
// shifted (the later slots plus the 4-byte free block head) and on the free
// blocks walked. A drop index out of range answers without touching the
// slots. Format clears all 4096 bytes before it writes the header. After
// reset the block runs the same clearing pass and header write before it
// takes its first transaction.
module slotted_page_cell_allocator_unit
    import spca_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // [11:0] alloc_size, [22:12] cell_index
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] op
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,  // [11:0] data_offset, [22:12] cell_count
    output logic      [1:0]  o_m_axis_tuser   // [1:0] status
);

    logic              w_idle, w_start, w_res_ready;
    t_ram_wr           w_wr;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;
    t_seq_res          w_res;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [11:0] r_out_data;
    logic [10:0] r_out_count;

    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid & w_idle;
    // the result register frees up as soon as its transaction completes
    assign w_res_ready     = !r_out_valid || i_m_axis_tready;

    spca_page_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    spca_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_op        (i_s_axis_tuser),
        .i_sz        (i_s_axis_tdata[11:0]),
        .i_idx       (i_s_axis_tdata[22:12]),
        .i_res_ready (w_res_ready),
        .i_rdata     (w_rdata),
        .o_idle      (w_idle),
        .o_wr        (w_wr),
        .o_raddr     (w_raddr),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done && w_res_ready) begin
            r_out_status <= w_res.status;
            r_out_data   <= w_res.data_offset;
            r_out_count  <= w_res.cell_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_count, r_out_data};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

[hw/rtl/spca_alu.sv]
// Shared add/subtract unit used by the steps of the sequencer.
`default_nettype none

module spca_alu
    import spca_pkg::*;
(
    input  wire logic [ALU_W-1:0] i_a,
    input  wire logic [ALU_W-1:0] i_b,
    input  wire logic             i_sub,
    output logic      [ALU_W-1:0] o_res
);

    // on a subtract the top bit is the borrow (operands stay below 2^17)
    assign o_res = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

`default_nettype wire

[hw/rtl/spca_page_ram.sv]
// Byte-wide page memory, one write port and one registered read port.
`default_nettype none

module spca_page_ram
    import spca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_ram_wr           i_wr,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [PAGE_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

[hw/rtl/spca_seq.sv]
// Microcoded sequencer: format, allocate and drop over the page memory.
`default_nettype none

module spca_seq
    import spca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_op,
    input  wire logic [11:0]       i_sz,
    input  wire logic [10:0]       i_idx,
    input  wire logic              i_res_ready,
    input  wire logic [7:0]        i_rdata,
    output logic                   o_idle,
    output t_ram_wr                o_wr,
    output logic      [ADDR_W-1:0] o_raddr,
    output t_seq_res               o_res
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CLEAR = 10'b00_0000_0010,
        S_EXEC  = 10'b00_0000_0100,
        S_RD0   = 10'b00_0000_1000,
        S_RD1   = 10'b00_0001_0000,
        S_WR0   = 10'b00_0010_0000,
        S_WR1   = 10'b00_0100_0000,
        S_CP0   = 10'b00_1000_0000,
        S_CP1   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    // microprogram steps
    typedef enum logic [6:0] {
        P_F0, P_F1, P_F2, P_F3, P_F4,
        P_A0, P_A1, P_A2, P_A3, P_A4, P_A5, P_A6, P_A7, P_A8, P_A8B,
        P_A9, P_A9B, P_A10, P_A10B, P_A11, P_A12, P_A13, P_A14, P_A15,
        P_A16, P_A17, P_A18, P_A19, P_A19B, P_A20, P_A21, P_A22, P_A23, P_A24,
        P_D0, P_D1, P_D2, P_D3, P_D4, P_D5, P_D6, P_D7, P_D8, P_D9, P_D10,
        P_D11, P_D12, P_D13, P_D14, P_D15, P_D16, P_D17, P_D18, P_D19, P_D20,
        P_D21, P_D22, P_D23, P_D24, P_D25, P_D26, P_D26B, P_D26C, P_D27,
        P_D28, P_D29, P_D30, P_D31, P_D32, P_D33, P_D34, P_D35,
        P_FIN, P_END
    } t_upc;

    t_state r_state, n_state;
    t_upc   r_pc, n_pc, r_ret, n_ret;
    logic   r_boot, n_boot;
    t_op    r_op, n_op;
    logic [11:0] r_sz, n_sz;
    logic [10:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_addr, n_addr, r_src, n_src, r_dst, n_dst;
    logic [15:0] r_wdata, n_wdata;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_n, n_n, r_top, n_top, r_prev, n_prev, r_curr, n_curr;
    logic [15:0] r_sz6, n_sz6, r_sz4, n_sz4, r_cell, n_cell, r_cap, n_cap;
    logic [15:0] r_tmp, n_tmp, r_cellp, n_cellp, r_nsz, n_nsz, r_ps, n_ps;
    logic [15:0] r_base, n_base;
    logic [IT_W-1:0]  r_it, n_it;
    logic [ALU_W-1:0] r_cnt, n_cnt;
    logic r_dir, n_dir, r_at_top, n_at_top;
    t_status r_status, n_status;
    logic [11:0] r_data, n_data;
    logic [10:0] r_count, n_count;

    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             alu_sub;
    logic [15:0]      w_val;

    spca_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    assign w_val = {i_rdata, r_lo};

    always_comb begin
        n_state = r_state; n_pc = r_pc; n_ret = r_ret; n_boot = r_boot;
        n_op = r_op; n_sz = r_sz; n_idx = r_idx; n_addr = r_addr;
        n_src = r_src; n_dst = r_dst; n_wdata = r_wdata; n_lo = r_lo;
        n_n = r_n; n_top = r_top; n_prev = r_prev; n_curr = r_curr;
        n_sz6 = r_sz6; n_sz4 = r_sz4; n_cell = r_cell; n_cap = r_cap;
        n_tmp = r_tmp; n_cellp = r_cellp; n_nsz = r_nsz; n_ps = r_ps;
        n_base = r_base; n_it = r_it; n_cnt = r_cnt; n_dir = r_dir;
        n_at_top = r_at_top; n_status = r_status; n_data = r_data;
        n_count = r_count;
        alu_a = '0; alu_b = '0; alu_sub = 1'b0;
        o_wr = '0;
        o_raddr = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = t_op'(i_op); n_sz = i_sz; n_idx = i_idx;
                    n_status = ST_OK; n_data = '0; n_at_top = 1'b0;
                    unique case (t_op'(i_op))
                        OP_FORMAT: begin n_state = S_CLEAR; n_src = '0; end
                        OP_ALLOC:  begin n_state = S_EXEC; n_pc = P_A0; end
                        OP_DROP:   begin n_state = S_EXEC; n_pc = P_D0; end
                        OP_NOP:    begin n_state = S_EXEC; n_pc = P_FIN; end
                        default:   begin n_state = S_EXEC; n_pc = P_FIN; end
                    endcase
                end
            end
            S_CLEAR: begin
                o_wr = '{we: 1'b1, addr: r_src, data: 8'd0};
                n_src = r_src + ADDR_W'(1);
                if (r_src == '1) begin
                    n_state = S_EXEC; n_pc = P_F0;
                end
            end
            S_RD0: begin
                o_raddr = r_addr;
                n_state = S_RD1;
            end
            S_RD1: begin
                alu_a = x18({{(16-ADDR_W){1'b0}}, r_addr}); alu_b = 18'd1;
                o_raddr = alu_res[ADDR_W-1:0];
                n_lo = i_rdata;
                n_state = S_EXEC; n_pc = r_ret;
            end
            S_WR0: begin
                o_wr = '{we: 1'b1, addr: r_addr, data: r_wdata[7:0]};
                n_state = S_WR1;
            end
            S_WR1: begin
                alu_a = x18({{(16-ADDR_W){1'b0}}, r_addr}); alu_b = 18'd1;
                o_wr = '{we: 1'b1, addr: alu_res[ADDR_W-1:0], data: r_wdata[15:8]};
                n_state = S_EXEC; n_pc = r_ret;
            end
            S_CP0: begin
                o_raddr = r_src;
                n_state = S_CP1;
            end
            S_CP1: begin
                o_wr = '{we: 1'b1, addr: r_dst, data: i_rdata};
                n_src = r_dir ? r_src - ADDR_W'(1) : r_src + ADDR_W'(1);
                n_dst = r_dir ? r_dst - ADDR_W'(1) : r_dst + ADDR_W'(1);
                n_cnt = r_cnt - 18'd1;
                if (r_cnt == 18'd1) begin
                    n_state = S_EXEC; n_pc = r_ret;
                end else begin
                    n_state = S_CP0;
                end
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            S_EXEC: begin
                unique case (r_pc)
                    // format: header after the clearing sweep
                    P_F0: begin n_addr = ADDR_W'(0); n_wdata = 16'd1;
                        n_ret = P_F1; n_state = S_WR0; end
                    P_F1: begin n_addr = ADDR_W'(2); n_wdata = 16'd12;
                        n_ret = P_F2; n_state = S_WR0; end
                    P_F2: begin n_addr = ADDR_W'(12); n_wdata = 16'd0;
                        n_ret = P_F3; n_state = S_WR0; end
                    P_F3: begin n_addr = ADDR_W'(14); n_wdata = 16'(PAGE_BYTES - 16);
                        n_ret = P_F4; n_state = S_WR0; end
                    P_F4: begin
                        if (r_boot) begin n_boot = 1'b0; n_state = S_IDLE; end
                        else n_pc = P_FIN;
                    end
                    // allocate
                    P_A0: begin n_addr = ADDR_W'(10); n_ret = P_A1; n_state = S_RD0; end
                    P_A1: begin
                        n_n = w_val;
                        alu_a = 18'd12; alu_b = {1'b0, w_val, 1'b0};
                        n_top = alu_res[15:0]; n_pc = P_A2;
                    end
                    P_A2: begin alu_a = x18(r_top); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_A3; n_state = S_RD0; end
                    P_A3: begin
                        alu_a = x18(w_val); alu_b = 18'd4; alu_sub = 1'b1;
                        if (alu_res[ALU_W-1]) begin
                            n_status = ST_NOSPACE; n_pc = P_FIN;
                        end else begin
                            n_addr = ADDR_W'(2); n_prev = 16'd2;
                            n_ret = P_A4; n_state = S_RD0;
                        end
                    end
                    P_A4: begin
                        n_curr = w_val; n_it = '0;
                        alu_a = x18({4'd0, r_sz}); alu_b = 18'd6;
                        n_sz6 = alu_res[15:0]; n_pc = P_A5;
                    end
                    P_A5: begin
                        if (r_curr == 16'd0 || r_it == IT_W'(PAGE_BYTES)) begin
                            n_status = ST_NOSPACE; n_pc = P_FIN;
                        end else begin
                            alu_a = x18(r_curr); alu_b = 18'd2;
                            n_addr = alu_res[ADDR_W-1:0]; n_ret = P_A6; n_state = S_RD0;
                        end
                    end
                    P_A6: begin
                        alu_a = x18({4'd0, r_sz}); alu_b = x18(w_val); alu_sub = 1'b1;
                        n_tmp = w_val;
                        if (!alu_res[ALU_W-1]) n_pc = P_A8;
                        else if (r_curr == r_top) n_pc = P_A7;
                        else n_pc = P_A9;
                    end
                    P_A7: begin
                        alu_a = x18(r_sz6); alu_b = x18(r_tmp); alu_sub = 1'b1;
                        if (!alu_res[ALU_W-1]) n_pc = P_A8;
                        else begin n_at_top = 1'b1; n_pc = P_A9; end
                    end
                    P_A8: begin n_prev = r_curr; n_addr = r_curr[ADDR_W-1:0];
                        n_ret = P_A8B; n_state = S_RD0; end
                    P_A8B: begin n_curr = w_val; n_it = r_it + IT_W'(1); n_pc = P_A5; end
                    // grow the slot array: move the first free head up two bytes
                    P_A9: begin alu_a = x18(r_top); alu_b = 18'd3;
                        n_src = alu_res[ADDR_W-1:0]; n_pc = P_A9B; end
                    P_A9B: begin
                        alu_a = x18(r_top); alu_b = 18'd5;
                        n_dst = alu_res[ADDR_W-1:0]; n_cnt = 18'd4; n_dir = 1'b1;
                        n_ret = P_A10; n_state = S_CP0;
                    end
                    P_A10: begin
                        alu_a = x18({4'd0, r_sz}); alu_b = 18'd4; n_sz4 = alu_res[15:0];
                        n_addr = ADDR_W'(2); n_ret = P_A10B; n_state = S_RD0;
                    end
                    P_A10B: begin alu_a = x18(w_val); alu_b = 18'd2;
                        n_wdata = alu_res[15:0]; n_ret = P_A11; n_state = S_WR0; end
                    P_A11: begin alu_a = x18(r_top); alu_b = 18'd4;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_A12; n_state = S_RD0; end
                    P_A12: begin alu_a = x18(w_val); alu_b = 18'd2; alu_sub = 1'b1;
                        n_wdata = alu_res[15:0]; n_ret = P_A13; n_state = S_WR0; end
                    P_A13: begin
                        alu_a = x18(r_top); alu_b = 18'd2;
                        if (r_at_top) n_curr = alu_res[15:0];
                        if (r_prev == r_top) n_prev = alu_res[15:0];
                        n_pc = P_A14;
                    end
                    P_A14: begin alu_a = x18(r_curr); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_A15; n_state = S_RD0; end
                    P_A15: begin
                        alu_a = x18(w_val); alu_b = x18(r_sz4); alu_sub = 1'b1;
                        if (alu_res[ALU_W-1]) begin n_cap = w_val; n_pc = P_A16; end
                        else begin n_tmp = alu_res[15:0]; n_pc = P_A18; end
                    end
                    P_A16: begin n_addr = r_curr[ADDR_W-1:0]; n_ret = P_A17;
                        n_state = S_RD0; end
                    P_A17: begin n_wdata = w_val; n_addr = r_prev[ADDR_W-1:0];
                        n_cell = r_curr; n_ret = P_A20; n_state = S_WR0; end
                    P_A18: begin alu_a = x18(r_curr); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_wdata = r_tmp;
                        n_ret = P_A19; n_state = S_WR0; end
                    P_A19: begin alu_a = x18(r_curr); alu_b = 18'd4;
                        n_cell = alu_res[15:0]; n_pc = P_A19B; end
                    P_A19B: begin alu_a = x18(r_cell); alu_b = x18(r_tmp);
                        n_cell = alu_res[15:0]; n_cap = {4'd0, r_sz}; n_pc = P_A20; end
                    P_A20: begin n_addr = r_top[ADDR_W-1:0]; n_wdata = r_cell;
                        n_ret = P_A21; n_state = S_WR0; end
                    P_A21: begin alu_a = x18(r_n); alu_b = 18'd1;
                        n_wdata = alu_res[15:0]; n_addr = ADDR_W'(10);
                        n_ret = P_A22; n_state = S_WR0; end
                    P_A22: begin alu_a = x18(r_cell); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_wdata = {4'd0, r_sz};
                        n_ret = P_A23; n_state = S_WR0; end
                    P_A23: begin n_addr = r_cell[ADDR_W-1:0]; n_wdata = r_cap;
                        n_ret = P_A24; n_state = S_WR0; end
                    P_A24: begin alu_a = x18(r_cell); alu_b = 18'd4;
                        n_data = alu_res[11:0]; n_status = ST_OK; n_pc = P_FIN; end
                    // drop
                    P_D0: begin n_addr = ADDR_W'(10); n_ret = P_D1; n_state = S_RD0; end
                    P_D1: begin
                        n_n = w_val;
                        alu_a = x18({5'd0, r_idx}); alu_b = x18(w_val); alu_sub = 1'b1;
                        if (!alu_res[ALU_W-1]) begin n_status = ST_RANGE; n_pc = P_FIN; end
                        else n_pc = P_D2;
                    end
                    P_D2: begin alu_a = x18(r_n); alu_b = 18'd1; alu_sub = 1'b1;
                        n_n = alu_res[15:0]; n_wdata = alu_res[15:0];
                        n_addr = ADDR_W'(10); n_ret = P_D3; n_state = S_WR0; end
                    P_D3: begin n_addr = ADDR_W'(2); n_ret = P_D4; n_state = S_RD0; end
                    P_D4: begin alu_a = x18(w_val); alu_b = 18'd2; alu_sub = 1'b1;
                        n_wdata = alu_res[15:0]; n_ret = P_D5; n_state = S_WR0; end
                    P_D5: begin
                        alu_a = 18'd12; alu_b = x18({4'd0, r_idx, 1'b0});
                        n_base = alu_res[15:0]; n_addr = alu_res[ADDR_W-1:0];
                        n_ret = P_D6; n_state = S_RD0;
                    end
                    P_D6: begin n_cellp = w_val;
                        alu_a = x18(r_n); alu_b = x18({5'd0, r_idx}); alu_sub = 1'b1;
                        n_tmp = alu_res[15:0]; n_pc = P_D7; end
                    P_D7: begin alu_a = {1'b0, r_tmp, 1'b0}; alu_b = 18'd4;
                        n_cnt = alu_res; n_pc = P_D8; end
                    P_D8: begin
                        alu_a = x18(r_base); alu_b = 18'd2;
                        n_src = alu_res[ADDR_W-1:0]; n_dst = r_base[ADDR_W-1:0];
                        n_dir = 1'b0; n_ret = P_D9; n_state = S_CP0;
                    end
                    P_D9: begin n_addr = ADDR_W'(2); n_ret = P_D10; n_state = S_RD0; end
                    P_D10: begin alu_a = x18(w_val); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D11; n_state = S_RD0; end
                    P_D11: begin alu_a = x18(w_val); alu_b = 18'd2;
                        n_wdata = alu_res[15:0]; n_ret = P_D12; n_state = S_WR0; end
                    P_D12: begin n_addr = r_cellp[ADDR_W-1:0]; n_ret = P_D13;
                        n_state = S_RD0; end
                    P_D13: begin n_wdata = w_val; alu_a = x18(r_cellp); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D14; n_state = S_WR0; end
                    P_D14: begin n_prev = 16'd2; n_addr = ADDR_W'(2); n_ret = P_D15;
                        n_state = S_RD0; end
                    P_D15: begin n_curr = w_val; n_it = '0; n_pc = P_D16; end
                    P_D16: begin
                        alu_a = x18(r_curr); alu_b = x18(r_cellp); alu_sub = 1'b1;
                        if (r_curr == 16'd0 || r_it == IT_W'(PAGE_BYTES)) n_pc = P_D18;
                        else if (!alu_res[ALU_W-1]) n_pc = P_D18;
                        else begin
                            n_prev = r_curr; n_addr = r_curr[ADDR_W-1:0];
                            n_ret = P_D17; n_state = S_RD0;
                        end
                    end
                    P_D17: begin n_curr = w_val; n_it = r_it + IT_W'(1); n_pc = P_D16; end
                    P_D18: begin n_addr = r_prev[ADDR_W-1:0]; n_wdata = r_cellp;
                        n_ret = P_D19; n_state = S_WR0; end
                    P_D19: begin n_addr = r_cellp[ADDR_W-1:0]; n_wdata = r_curr;
                        n_ret = P_D20; n_state = S_WR0; end
                    P_D20: begin alu_a = x18(r_cellp); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D21; n_state = S_RD0; end
                    P_D21: begin n_nsz = w_val; alu_a = x18(r_cellp); alu_b = 18'd4;
                        n_tmp = alu_res[15:0]; n_pc = P_D22; end
                    P_D22: begin
                        alu_a = x18(r_tmp); alu_b = x18(r_nsz);
                        if (r_curr != 16'd0 && alu_res[15:0] == r_curr) n_pc = P_D23;
                        else n_pc = P_D27;
                    end
                    // merge with the following free block
                    P_D23: begin n_addr = r_curr[ADDR_W-1:0]; n_ret = P_D24;
                        n_state = S_RD0; end
                    P_D24: begin n_wdata = w_val; n_addr = r_cellp[ADDR_W-1:0];
                        n_ret = P_D25; n_state = S_WR0; end
                    P_D25: begin alu_a = x18(r_curr); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D26; n_state = S_RD0; end
                    P_D26: begin alu_a = x18(w_val); alu_b = x18(r_nsz);
                        n_tmp = alu_res[15:0]; n_pc = P_D26B; end
                    P_D26B: begin alu_a = x18(r_tmp); alu_b = 18'd4;
                        n_wdata = alu_res[15:0]; n_pc = P_D26C; end
                    P_D26C: begin alu_a = x18(r_cellp); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D27; n_state = S_WR0; end
                    // merge with the preceding free block
                    P_D27: begin
                        if (r_prev == 16'd2) n_pc = P_FIN;
                        else begin
                            alu_a = x18(r_prev); alu_b = 18'd2;
                            n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D28; n_state = S_RD0;
                        end
                    end
                    P_D28: begin n_ps = w_val; alu_a = x18(r_prev); alu_b = 18'd4;
                        n_tmp = alu_res[15:0]; n_pc = P_D29; end
                    P_D29: begin
                        alu_a = x18(r_tmp); alu_b = x18(r_ps);
                        if (alu_res[15:0] == r_cellp) n_pc = P_D30;
                        else n_pc = P_FIN;
                    end
                    P_D30: begin n_addr = r_cellp[ADDR_W-1:0]; n_ret = P_D31;
                        n_state = S_RD0; end
                    P_D31: begin n_wdata = w_val; n_addr = r_prev[ADDR_W-1:0];
                        n_ret = P_D32; n_state = S_WR0; end
                    P_D32: begin alu_a = x18(r_cellp); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_D33; n_state = S_RD0; end
                    P_D33: begin alu_a = x18(r_ps); alu_b = x18(w_val);
                        n_tmp = alu_res[15:0]; n_pc = P_D34; end
                    P_D34: begin alu_a = x18(r_tmp); alu_b = 18'd4;
                        n_wdata = alu_res[15:0]; n_pc = P_D35; end
                    P_D35: begin alu_a = x18(r_prev); alu_b = 18'd2;
                        n_addr = alu_res[ADDR_W-1:0]; n_ret = P_FIN; n_state = S_WR0; end
                    // every operation reports the stored cell count
                    P_FIN: begin n_addr = ADDR_W'(10); n_ret = P_END; n_state = S_RD0; end
                    P_END: begin n_count = w_val[10:0]; n_state = S_DONE; end
                    default: begin n_pc = P_FIN; end
                endcase
            end
            default: begin n_state = S_IDLE; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_src   <= '0;
            r_boot  <= 1'b1;
            r_pc    <= P_F0;
            r_ret   <= P_F0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_boot  <= n_boot;
            r_pc    <= n_pc;
            r_ret   <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_sz <= n_sz; r_idx <= n_idx; r_addr <= n_addr;
        r_dst <= n_dst; r_wdata <= n_wdata; r_lo <= n_lo;
        r_n <= n_n; r_top <= n_top; r_prev <= n_prev; r_curr <= n_curr;
        r_sz6 <= n_sz6; r_sz4 <= n_sz4; r_cell <= n_cell; r_cap <= n_cap;
        r_tmp <= n_tmp; r_cellp <= n_cellp; r_nsz <= n_nsz; r_ps <= n_ps;
        r_base <= n_base; r_it <= n_it; r_cnt <= n_cnt; r_dir <= n_dir;
        r_at_top <= n_at_top; r_status <= n_status; r_data <= n_data;
        r_count <= n_count;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_res  = '{done: (r_state == S_DONE), status: r_status,
                      data_offset: r_data, cell_count: r_count};

endmodule

`default_nettype wire

[hw/rtl/spca_checker.sv]
// Port-level checks for the slotted page cell allocator, bound to the top.
`default_nettype none

module spca_checker
    import spca_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        i_s_axis_tready,
    input wire logic        i_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] i_m_axis_tdata,
    input wire logic [1:0]  i_m_axis_tuser
);

    // one operation at a time: the slave side closes right after an accept
    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("input accepted while an operation was in flight");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> i_m_axis_tuser != 2'd3)
        else $error("undefined status code");

    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser != ST_OK |-> i_m_axis_tdata[11:0] == 12'd0)
        else $error("failed operation reported an offset");

endmodule

bind slotted_page_cell_allocator_unit spca_checker u_spca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

[bench/spca_checker.sv]
// Checker for the slotted page cell allocator: page predictor and result compare.
`timescale 1ns / 100ps

module spca_scoreboard
    import spca_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,
    input  wire logic [1:0]  i_s_axis_tuser,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [23:0] i_m_axis_tdata,
    input  wire logic [1:0]  i_m_axis_tuser,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        t_status     status;
        logic [11:0] data_offset;
        logic [10:0] cell_count;
    } t_answer;

    logic [7:0] page [PAGE_BYTES];
    t_answer    answers_due [$];

    function automatic int wrap(int a);
        return a % PAGE_BYTES;
    endfunction

    function automatic int get16(int a);
        return int'(page[wrap(a)]) | (int'(page[wrap(a + 1)]) << 8);
    endfunction

    task automatic put16(int a, int v);
        page[wrap(a)]     = v[7:0];
        page[wrap(a + 1)] = v[15:8];
    endtask

    task automatic wipe_page();
        for (int i = 0; i < PAGE_BYTES; i++) page[i] = 8'h00;
        put16(0, 1);
        put16(2, 12);
        put16(12, 0);
        put16(14, PAGE_BYTES - 16);
    endtask

    task automatic carve_cell(int sz, output t_status st, output int data);
        int  n, top, prev, curr, s, cell_sz, cell_at, cap, left;
        bit  found, at_top, skip;
        n = get16(10);
        top = 12 + 2 * n;
        prev = 2;
        curr = get16(2);
        found = 0;
        at_top = 0;
        data = 0;
        st = ST_NOSPACE;
        if (get16(top + 2) < 4) return;
        for (int it = 0; curr != 0 && it < PAGE_BYTES; it++) begin
            s = get16(curr + 2);
            skip = (s <= sz);
            if (!skip && curr == top) begin
                if (s <= sz + 6) skip = 1;
                else at_top = 1;
            end
            if (!skip) begin
                found = 1;
                break;
            end
            prev = curr;
            curr = get16(curr);
        end
        if (!found) return;
        // first free block head slides up two bytes to make room for the new slot
        for (int i = 4; i > 0; i--) page[wrap(top + 1 + i)] = page[wrap(top + i - 1)];
        put16(2, (get16(2) + 2) & 16'hFFFF);
        put16(top + 4, (get16(top + 4) - 2) & 16'hFFFF);
        if (at_top) curr = top + 2;
        if (prev == top) prev = top + 2;
        cell_sz = get16(curr + 2);
        if (cell_sz < sz + 4) begin
            put16(prev, get16(curr));
            cell_at = curr;
            cap = cell_sz;
        end else begin
            left = (cell_sz - sz - 4) & 16'hFFFF;
            put16(curr + 2, left);
            cell_at = (curr + 4 + left) & 16'hFFFF;
            cap = sz;
        end
        put16(top, cell_at);
        put16(10, (n + 1) & 16'hFFFF);
        put16(cell_at + 2, sz);
        put16(cell_at, cap);
        data = (cell_at + 4) & 16'hFFFF;
        st = ST_OK;
    endtask

    task automatic free_cell(int idx, output t_status st);
        int n, cellp, len, prev, curr, first, nsz;
        n = get16(10);
        st = ST_RANGE;
        if (idx >= n) return;
        n = n - 1;
        put16(10, n);
        put16(2, (get16(2) - 2) & 16'hFFFF);
        cellp = get16(12 + 2 * idx);
        len = 2 * (n - idx) + 4;
        for (int i = 0; i < len; i++)
            page[wrap(12 + 2 * idx + i)] = page[wrap(12 + 2 * idx + 2 + i)];
        first = get16(2);
        put16(first + 2, (get16(first + 2) + 2) & 16'hFFFF);
        put16(cellp + 2, get16(cellp));
        prev = 2;
        curr = get16(2);
        for (int it = 0; curr != 0 && it < PAGE_BYTES; it++) begin
            if (curr >= cellp) break;
            prev = curr;
            curr = get16(curr);
        end
        put16(prev, cellp);
        put16(cellp, curr);
        nsz = get16(cellp + 2);
        // merge with the block above, then with the one below
        if (curr != 0 && ((cellp + 4 + nsz) & 16'hFFFF) == curr) begin
            put16(cellp, get16(curr));
            put16(cellp + 2, (nsz + 4 + get16(curr + 2)) & 16'hFFFF);
        end
        if (prev != 2 && ((prev + 4 + get16(prev + 2)) & 16'hFFFF) == cellp) begin
            put16(prev, get16(cellp));
            put16(prev + 2, (get16(prev + 2) + 4 + get16(cellp + 2)) & 16'hFFFF);
        end
        st = ST_OK;
    endtask

    task automatic apply_op(t_op op, int sz, int idx);
        t_answer a;
        t_status st;
        int      data;
        st = ST_OK;
        data = 0;
        case (op)
            OP_FORMAT: wipe_page();
            OP_ALLOC:  carve_cell(sz, st, data);
            OP_DROP:   free_cell(idx, st);
            default: ;
        endcase
        a.status      = st;
        a.data_offset = data[11:0];
        a.cell_count  = 11'(get16(10));
        answers_due.insert(answers_due.size(), a);
    endtask

    always @(posedge i_clk) begin
        t_answer want, got;
        if (!i_rst_n) begin
            wipe_page();
            answers_due.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                apply_op(t_op'(i_s_axis_tuser), int'(i_s_axis_tdata[11:0]),
                         int'(i_s_axis_tdata[22:12]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status      = t_status'(i_m_axis_tuser);
                got.data_offset = i_m_axis_tdata[11:0];
                got.cell_count  = i_m_axis_tdata[22:12];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want || i_m_axis_tdata[23] !== 1'b0) begin
                        $display("%0t: mismatch expected st=%0d off=%0d cnt=%0d",
                                 $realtime, want.status, want.data_offset, want.cell_count);
                        $display("%0t:          actual   st=%0d off=%0d cnt=%0d",
                                 $realtime, got.status, got.data_offset, got.cell_count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= answers_due.size();
        end
    end

endmodule

[bench/tb_slotted_page_cell_allocator_unit.sv]
// Testbench top for the slotted page cell allocator: stimulus and verdict.
`timescale 1ns / 100ps

module tb_slotted_page_cell_allocator_unit;
    import spca_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [11:0] alloc_size, [22:12] cell_index
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [11:0] data_offset, [22:12] cell_count
    logic [1:0]  m_tuser;   // [1:0] status
    int          fail_count;
    int          pending;
    int          live_cells;

    slotted_page_cell_allocator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    spca_scoreboard u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // one input transaction; valid stays up across back-to-back items
    task automatic send_op(t_op op, int sz, int idx);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, idx[10:0], sz[11:0]};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_FORMAT) live_cells = 0;
    endtask

    // receiver stalls at random
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            m_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // cell count is tracked from the result stream to aim drops at live slots
    always @(posedge i_clk)
        if (m_tvalid && m_tready) live_cells = int'(m_tdata[22:12]);

    initial begin
        int sz, idx, r, drain;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_NOP;
        i_rst_n  = 1'b0;
        live_cells = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every op, range errors, no-op
        send_op(OP_NOP, 12'hFFF, 11'h7FF);
        send_op(OP_DROP, 0, 0);
        send_op(OP_DROP, 0, 2047);
        send_op(OP_ALLOC, 4095, 0);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 4070, 0);
        send_op(OP_ALLOC, 100, 2047);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_DROP, 0, 1);
        send_op(OP_ALLOC, 50, 0);
        send_op(OP_DROP, 0, 5);
        send_op(OP_DROP, 0, 0);
        send_op(OP_NOP, 0, 0);
        send_op(OP_FORMAT, 4095, 2047);
        for (int i = 0; i < 6; i++) send_op(OP_ALLOC, 600, 0);
        send_op(OP_DROP, 0, 2);
        send_op(OP_DROP, 0, 2);
        send_op(OP_ALLOC, 1000, 0);
        send_op(OP_FORMAT, 0, 0);

        // random: alloc/drop mix with rare formats and no-ops, mostly small cells, drops mostly in range
        for (int n = 0; n < 400; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) send_op(OP_FORMAT, $urandom_range(0, 4095), $urandom_range(0, 2047));
            else if (r < 4) send_op(OP_NOP, $urandom_range(0, 4095), $urandom_range(0, 2047));
            else if (r < 55) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 200);
                send_op(OP_ALLOC, sz, $urandom_range(0, 2047));
            end else begin
                if ($urandom_range(0, 9) == 0 || live_cells == 0)
                    idx = $urandom_range(0, 2047);
                else
                    idx = $urandom_range(0, live_cells - 1);
                send_op(OP_DROP, $urandom_range(0, 4095), idx);
            end
        end
        s_tvalid <= 1'b0;

        // wait until the registered count of outstanding results drops to zero
        drain = 0;
        do begin
            @(posedge i_clk);
            drain++;
        end while (pending != 0 && drain < 200000);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
